// File: sv/apts_pkg.sv
package apts_pkg;

	// Field widths fixed by the item format.
	localparam int TW = 32;
	localparam int PW = 8;
	localparam int DW = 16;
	localparam int SW = 8;
	localparam int IW = 4;
	localparam int WW = 5;

	// Divider step counter width.
	localparam int DCW = $clog2(TW);

	// Reset value of the realtime level register.
	localparam logic [PW-1:0] RT_RESET = 8'd6;

	// Saturation limit of the waiting count.
	localparam logic [WW-1:0] WAIT_MAX = '1;

	typedef enum logic {
		CMD_SET   = 1'b0,
		CMD_SCHED = 1'b1
	} cmd_t;

	// One request as held in the queue.
	typedef struct packed {
		cmd_t          cmd;
		logic [IW-1:0] idx;
		logic          en;
		logic [PW-1:0] prio;
		logic [TW-1:0] period;
		logic [TW-1:0] now;
		logic          in_range;
	} item_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} fe_q_t;

	// One task record in the task table.
	typedef struct packed {
		logic [PW-1:0] prio;
		logic [TW-1:0] period;
		logic [TW-1:0] last;
		logic [DW-1:0] dyn;
		logic [SW-1:0] stamp;
	} rec_t;

	localparam rec_t REC_RESET = '{prio: '0, period: '1, last: '0, dyn: '0, stamp: '0};

	// One result.
	typedef struct packed {
		logic          sel_valid;
		logic [IW-1:0] sel_task;
		logic [WW-1:0] waiting;
		logic          set_acc;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_SET_UPD,
		ST_DIS_RD,
		ST_DIS_UPD,
		ST_GRD_RD,
		ST_GRD_CHK,
		ST_SEL_RD,
		ST_SEL_LD,
		ST_SEL_DIV,
		ST_SEL_MUL,
		ST_SEL_EVAL,
		ST_COMMIT
	} state_t;

endpackage

// File: sv/apts_ram.sv
module apts_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/apts_div.sv
module apts_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [apts_pkg::TW-1:0] dividend,
	input  logic [apts_pkg::TW-1:0] divisor,
	output logic                  done,
	output logic [apts_pkg::TW-1:0] quotient
);
	import apts_pkg::*;

	logic           busy_q;
	logic           done_q;
	logic [DCW-1:0] cnt_q;
	logic [TW-1:0]  rem_q;
	logic [TW-1:0]  quo_q;
	logic [TW-1:0]  div_q;
	logic [TW:0]    shifted;
	logic [TW:0]    diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, quo_q[TW-1]};
		diff    = shifted - {1'b0, div_q};
	end

	// Control of the iteration, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCW'(TW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[TW]) begin
				rem_q <= diff[TW-1:0];
				quo_q <= {quo_q[TW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TW-1:0];
				quo_q <= {quo_q[TW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/apts_fe.sv
module apts_fe #(
	parameter int TASK_SLOTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [apts_pkg::IW-1:0]   task_index,
	input  logic                      enable,
	input  logic [apts_pkg::PW-1:0]   static_priority,
	input  logic [apts_pkg::TW-1:0]   period,
	input  logic [apts_pkg::TW-1:0]   current_time,
	output apts_pkg::fe_q_t           head,
	input  logic                      pop
);
	import apts_pkg::*;

	item_t      slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      item_in;

	// Classify the request: an index beyond the table is marked here.
	always_comb begin
		item_in.cmd      = cmd_t'(command);
		item_in.idx      = task_index;
		item_in.en       = enable;
		item_in.prio     = static_priority;
		item_in.period   = period;
		item_in.now      = current_time;
		item_in.in_range = 32'(task_index) < 32'(TASK_SLOTS);
	end

	assign in_stall = cnt_q == 2'd2;
	assign push     = in_valid && !in_stall;

	// Two-entry queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= item_in;
		end
	end

	assign head.valid = cnt_q != 2'd0;
	assign head.item  = slot_q[rp_q];

endmodule

// File: sv/apts_be.sv
module apts_be #(
	parameter int TASK_SLOTS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [apts_pkg::PW-1:0] rt_level,
	input  apts_pkg::fe_q_t         head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output apts_pkg::res_t          res
);
	import apts_pkg::*;

	localparam int AW = $clog2(TASK_SLOTS);

	state_t          state_q, state_d;
	logic [AW-1:0]   i_q, i_d;
	item_t           item_q, item_d;
	logic            guard_q, guard_d;
	logic            found_q, found_d;
	logic [AW-1:0]   best_idx_q, best_idx_d;
	rec_t            best_q, best_d;
	rec_t            rec_q, rec_d;
	logic [WW-1:0]   waiting_q, waiting_d;
	logic [TW-1:0]   age_q, age_d;
	logic [DW-1:0]   prod_q, prod_d;
	logic [SW-1:0]   ts_q, ts_d;
	logic [SW-1:0]   stamp_cnt_q, stamp_cnt_d;
	logic [TASK_SLOTS-1:0] en_q, en_d;
	logic [TASK_SLOTS-1:0] touched_q, touched_d;
	logic            out_valid_q, out_valid_d;
	res_t            res_q, res_d;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	rec_t            ram_wdata;
	logic [AW-1:0]   ram_raddr;
	rec_t            ram_rdata;
	rec_t            rd_rec;
	logic            div_start;
	logic            div_done;
	logic [TW-1:0]   div_quo;
	logic [AW+IW-1:0] idx_wide;
	logic [AW-1:0]   addr_in;
	logic [AW+IW-1:0] best_wide;
	logic            last_i;
	logic [TW-1:0]   diff;
	logic [TW-1:0]   guard_diff;
	logic [PW+DW-1:0] mul;
	logic [DW-1:0]   dyn_new;
	logic            allowed;
	logic            better;

	apts_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(TASK_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	apts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (rd_rec.period),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Index helpers between the four-bit task field and the table address.
	assign idx_wide  = {{AW{1'b0}}, head.item.idx};
	assign addr_in   = idx_wide[AW-1:0];
	assign best_wide = {{IW{1'b0}}, best_idx_q};
	assign last_i    = i_q == AW'(TASK_SLOTS - 1);

	// A record never written reads as its reset value.
	assign rd_rec = touched_q[i_q] ? ram_rdata : REC_RESET;

	// Scan datapath: time since last run, guard test and aged priority.
	always_comb begin
		diff       = item_q.now - rd_rec.last;
		guard_diff = item_q.now - (rd_rec.last + rd_rec.period);
		mul        = rec_q.prio * age_q[DW-1:0];
		dyn_new    = (age_q != '0) ? prod_q + 1'b1 : rec_q.dyn;
		allowed    = !guard_q || (|age_q[TW-1:1]) || rec_q.prio >= rt_level;
		better     = (dyn_new > best_q.dyn)
			|| (dyn_new == best_q.dyn && rec_q.prio > best_q.prio)
			|| (dyn_new == best_q.dyn && rec_q.prio == best_q.prio
				&& rec_q.stamp < best_q.stamp);
	end

	// Sequencer: set commands, the disable sweep and the two scan passes.
	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		item_d      = item_q;
		guard_d     = guard_q;
		found_d     = found_q;
		best_idx_d  = best_idx_q;
		best_d      = best_q;
		rec_d       = rec_q;
		waiting_d   = waiting_q;
		age_d       = age_q;
		prod_d      = prod_q;
		ts_d        = ts_q;
		stamp_cnt_d = stamp_cnt_q;
		en_d        = en_q;
		touched_d   = touched_q;
		out_valid_d = out_valid_q && out_stall;
		res_d       = res_q;
		ram_we      = 1'b0;
		ram_waddr   = i_q;
		ram_wdata   = rd_rec;
		ram_raddr   = i_q;
		pop         = 1'b0;
		div_start   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (head.valid && !out_valid_q) begin
					pop       = 1'b1;
					item_d    = head.item;
					guard_d   = 1'b0;
					found_d   = 1'b0;
					waiting_d = '0;
					res_d     = '0;
					if (head.item.cmd == CMD_SCHED) begin
						i_d     = '0;
						state_d = ST_GRD_RD;
					end else if (!head.item.in_range
						|| (head.item.en == en_q[addr_in])) begin
						out_valid_d = 1'b1;
					end else begin
						i_d     = addr_in;
						state_d = ST_SET_RD;
					end
				end
			end
			ST_SET_RD: begin
				state_d = ST_SET_UPD;
			end
			ST_SET_UPD: begin
				ram_we = 1'b1;
				if (item_q.en) begin
					ram_wdata.prio   = item_q.prio;
					ram_wdata.period = (item_q.period == '0) ? TW'(1) : item_q.period;
					ram_wdata.stamp  = stamp_cnt_q;
					en_d[i_q]        = 1'b1;
					touched_d[i_q]   = 1'b1;
					stamp_cnt_d      = stamp_cnt_q + 1'b1;
					res_d.set_acc    = 1'b1;
					out_valid_d      = 1'b1;
					state_d          = ST_IDLE;
				end else begin
					ram_wdata.stamp = '0;
					ts_d            = rd_rec.stamp;
					en_d[i_q]       = 1'b0;
					if (stamp_cnt_q != '0) begin
						stamp_cnt_d = stamp_cnt_q - 1'b1;
					end
					i_d     = '0;
					state_d = ST_DIS_RD;
				end
			end
			ST_DIS_RD: begin
				state_d = ST_DIS_UPD;
			end
			ST_DIS_UPD: begin
				// Close the gap left in the enable order.
				if (en_q[i_q] && rd_rec.stamp > ts_q) begin
					ram_we          = 1'b1;
					ram_wdata.stamp = rd_rec.stamp - 1'b1;
				end
				if (last_i) begin
					res_d.set_acc = 1'b1;
					out_valid_d   = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_DIS_RD;
				end
			end
			ST_GRD_RD: begin
				state_d = ST_GRD_CHK;
			end
			ST_GRD_CHK: begin
				if (en_q[i_q] && rd_rec.prio >= rt_level && !guard_diff[TW-1]) begin
					guard_d = 1'b1;
				end
				if (last_i) begin
					i_d     = '0;
					state_d = ST_SEL_RD;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_GRD_RD;
				end
			end
			ST_SEL_RD: begin
				state_d = ST_SEL_LD;
			end
			ST_SEL_LD: begin
				rec_d = rd_rec;
				if (!en_q[i_q]) begin
					if (last_i) begin
						state_d = ST_COMMIT;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_SEL_RD;
					end
				end else if (diff[TW-1]) begin
					age_d   = '0;
					state_d = ST_SEL_MUL;
				end else begin
					div_start = 1'b1;
					state_d   = ST_SEL_DIV;
				end
			end
			ST_SEL_DIV: begin
				if (div_done) begin
					age_d   = div_quo;
					state_d = ST_SEL_MUL;
				end
			end
			ST_SEL_MUL: begin
				prod_d  = mul[DW-1:0];
				state_d = ST_SEL_EVAL;
			end
			ST_SEL_EVAL: begin
				if (age_q != '0) begin
					ram_we        = 1'b1;
					ram_wdata     = rec_q;
					ram_wdata.dyn = dyn_new;
					if (waiting_q != WAIT_MAX) begin
						waiting_d = waiting_q + 1'b1;
					end
				end
				if (allowed && dyn_new != '0 && (!found_q || better)) begin
					found_d    = 1'b1;
					best_idx_d = i_q;
					best_d     = rec_q;
					best_d.dyn = dyn_new;
				end
				if (last_i) begin
					state_d = ST_COMMIT;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_SEL_RD;
				end
			end
			ST_COMMIT: begin
				// Mark the chosen task as run now.
				if (found_q) begin
					ram_we         = 1'b1;
					ram_waddr      = best_idx_q;
					ram_wdata      = best_q;
					ram_wdata.last = item_q.now;
					ram_wdata.dyn  = '0;
				end
				res_d.sel_valid = found_q;
				res_d.sel_task  = found_q ? best_wide[IW-1:0] : '0;
				res_d.waiting   = waiting_q;
				res_d.set_acc   = 1'b0;
				out_valid_d     = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stamp_cnt_q <= '0;
			en_q        <= '0;
			touched_q   <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			guard_q     <= 1'b0;
			i_q         <= '0;
		end else begin
			state_q     <= state_d;
			stamp_cnt_q <= stamp_cnt_d;
			en_q        <= en_d;
			touched_q   <= touched_d;
			out_valid_q <= out_valid_d;
			found_q     <= found_d;
			guard_q     <= guard_d;
			i_q         <= i_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		item_q     <= item_d;
		best_idx_q <= best_idx_d;
		best_q     <= best_d;
		rec_q      <= rec_d;
		waiting_q  <= waiting_d;
		age_q      <= age_d;
		prod_q     <= prod_d;
		ts_q       <= ts_d;
		res_q      <= res_d;
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// File: sv/aging_priority_task_scheduler_core.sv
// Aging-priority task scheduler.
// Requests enter on the input channel (in_valid / in_stall) and land in a
// two-entry queue; in_stall rises only when that queue is full. Each request
// gives exactly one result on the output channel (out_valid / out_stall),
// held in an output register until the receiver takes it; a stalled result
// keeps its value and further requests still queue up behind it.
// A set request enables or disables one task; a disable sweeps the table to
// close up the enable order. A schedule request makes one guard pass over
// the table, then a selection pass that sends each enabled task whose time
// since its last run is not negative through a shared serial divider, one
// quotient bit a cycle. A request leaves the queue only when the block is
// idle and the output register is empty. The user writes the realtime level
// through cfg_we / cfg_wdata only while the block is idle; the block does not
// enforce this. Reset clears the task table to all tasks disabled and never
// run, empties the queue and the output register, and loads realtime level 6.
module aging_priority_task_scheduler_core #(
	parameter int TASK_SLOTS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [apts_pkg::PW-1:0] cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic [apts_pkg::IW-1:0] task_index,
	input  logic                    enable,
	input  logic [apts_pkg::PW-1:0] static_priority,
	input  logic [apts_pkg::TW-1:0] period,
	input  logic [apts_pkg::TW-1:0] current_time,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    selected_valid,
	output logic [apts_pkg::IW-1:0] selected_task,
	output logic [apts_pkg::WW-1:0] waiting_count,
	output logic                    set_accepted
);
	import apts_pkg::*;

	logic [PW-1:0] rt_level_q;
	fe_q_t         head;
	logic          pop;
	res_t          res;

	// Realtime level register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_level_q <= RT_RESET;
		end else if (cfg_we) begin
			rt_level_q <= cfg_wdata;
		end
	end

	apts_fe #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_fe (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.task_index      (task_index),
		.enable          (enable),
		.static_priority (static_priority),
		.period          (period),
		.current_time    (current_time),
		.head            (head),
		.pop             (pop)
	);

	apts_be #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_be (
		.clk       (clk),
		.arst_n    (arst_n),
		.rt_level  (rt_level_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign selected_valid = res.sel_valid;
	assign selected_task  = res.sel_task;
	assign waiting_count  = res.waiting;
	assign set_accepted   = res.set_acc;

	// A set result never reports a decision.
	a_set_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && set_accepted |-> !selected_valid && waiting_count == '0)
		else $error("set result carries decision fields");

	// The back end only takes a request from a non-empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	// A new result is only started when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_valid)
		else $error("request taken while a result is pending");

	// No more tasks can wait than the table holds.
	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(waiting_count) <= 32'(TASK_SLOTS))
		else $error("waiting count beyond table size");

endmodule
